// ===== hw/rtl/hpa_pkg.sv =====
// ----------------------------------------------------------------------------
// hpa_pkg
// Shared types and constants of the handle pool allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package hpa_pkg;

   localparam int unsigned POOL_SIZE    = 256;
   localparam int unsigned HANDLE_SPACE = 256;
   localparam int unsigned HANDLES      = (POOL_SIZE < HANDLE_SPACE) ? POOL_SIZE : HANDLE_SPACE;
   localparam int unsigned HANDLE_W     = 8;
   localparam int unsigned COUNT_W      = 9;

   // opcodes
   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_TRY   = 2'd1;
   localparam logic [1:0] OP_FREE  = 2'd2;

   // status codes
   localparam logic [1:0] STS_OK         = 2'd0;
   localparam logic [1:0] STS_EMPTY      = 2'd1;
   localparam logic [1:0] STS_NOT_IN_USE = 2'd2;

   typedef struct packed {
      logic [1:0]          opcode;
      logic [HANDLE_W-1:0] release_handle;
   } req_type;

   typedef struct packed {
      logic [HANDLE_W-1:0] granted_handle;
      logic [1:0]          status;
   } rsp_type;

   // queue pointer advance, wraps at the pool size
   function automatic logic [HANDLE_W-1:0] ring_next(input logic [HANDLE_W-1:0] p);
      logic [HANDLE_W-1:0] last;
      last = HANDLE_W'(HANDLES - 1);
      return (p == last) ? '0 : p + 1'b1;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/hpa_ram.sv =====
// ----------------------------------------------------------------------------
// hpa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hpa_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/handle_pool_allocator.sv =====
// ----------------------------------------------------------------------------
// handle_pool_allocator
// Hands out numbered handles from a fixed pool, recycling freed ones FIFO.
// ----------------------------------------------------------------------------
// One request beat is handled at a time: the accept cycle issues the RAM
// reads (freed-queue head and the in-use bit of the released handle), and
// the execute step then checks the registered read data, writes back the
// bitmap and queue, and loads the response register. A new request beat is
// accepted only once the execute step of the last one is done, so a waiting
// response stalls the execute step and with it the next request accept.
// Allocate pops the oldest freed handle or else mints the next fresh one;
// try-allocate only pops. Deallocating a handle not in use returns an error
// status and changes nothing. In-use bits are cleared at reset through a
// valid bit per entry, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module handle_pool_allocator (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_ready,
   input  wire hpa_pkg::req_type req_data,
   output      logic             rsp_valid,
   input  wire logic             rsp_ready,
   output      hpa_pkg::rsp_type rsp_data
);

   import hpa_pkg::*;

   typedef enum logic {S_IDLE, S_EXEC} state_type;

   state_type           state_ff;
   logic [1:0]          op_ff;
   logic [HANDLE_W-1:0] rel_ff;
   logic [HANDLE_W-1:0] head_ff, head_in;
   logic [HANDLE_W-1:0] tail_ff, tail_in;
   logic [COUNT_W-1:0]  qcount_ff, qcount_in;
   logic [COUNT_W-1:0]  fresh_ff, fresh_in;
   logic [HANDLE_SPACE-1:0] vld_ff;   // bitmap entry written since reset
   logic                rsp_valid_ff;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic                accept;
   logic                fire;
   logic                in_use;

   logic                map_we, map_wdata, map_rdata;
   logic [HANDLE_W-1:0] map_waddr;
   logic                q_we;
   logic [HANDLE_W-1:0] q_rdata;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   // execute only when the response register is free or draining
   assign fire      = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign in_use    = vld_ff[rel_ff] & map_rdata;

   // freed-handle queue
   hpa_ram #(.WIDTH(HANDLE_W), .DEPTH(HANDLE_SPACE)) u_queue (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (tail_ff),
      .wr_data (rel_ff),
      .rd_en   (accept),
      .rd_addr (head_ff),
      .rd_data (q_rdata)
   );

   // in-use bitmap
   hpa_ram #(.WIDTH(1), .DEPTH(HANDLE_SPACE)) u_map (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_waddr),
      .wr_data (map_wdata),
      .rd_en   (accept),
      .rd_addr (req_data.release_handle),
      .rd_data (map_rdata)
   );

   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      qcount_in   = qcount_ff;
      fresh_in    = fresh_ff;
      map_we      = 1'b0;
      map_waddr   = rel_ff;
      map_wdata   = 1'b0;
      q_we        = 1'b0;
      rsp_data_in = '{granted_handle: '0, status: STS_OK};
      if (fire) begin
         priority if (op_ff == OP_ALLOC || op_ff == OP_TRY) begin
            priority if (qcount_ff != '0) begin
               rsp_data_in.granted_handle = q_rdata;
               head_in   = ring_next(head_ff);
               qcount_in = qcount_ff - 1'b1;
               map_we    = 1'b1;
               map_waddr = q_rdata;
               map_wdata = 1'b1;
            end else if (op_ff == OP_ALLOC && fresh_ff < COUNT_W'(HANDLES)) begin
               rsp_data_in.granted_handle = fresh_ff[HANDLE_W-1:0];
               fresh_in  = fresh_ff + 1'b1;
               map_we    = 1'b1;
               map_waddr = fresh_ff[HANDLE_W-1:0];
               map_wdata = 1'b1;
            end else begin
               rsp_data_in.status = STS_EMPTY;
            end
         end else if (op_ff == OP_FREE) begin
            if (!in_use) begin
               rsp_data_in.status = STS_NOT_IN_USE;
            end else begin
               map_we    = 1'b1;
               map_wdata = 1'b0;
               q_we      = 1'b1;
               tail_in   = ring_next(tail_ff);
               qcount_in = qcount_ff + 1'b1;
            end
         end else begin
            // unused opcode: no state change, ok status
            rsp_data_in.status = STS_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         qcount_ff    <= '0;
         fresh_ff     <= '0;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         qcount_ff <= qcount_in;
         fresh_ff  <= fresh_in;
         if (map_we) begin
            vld_ff[map_waddr] <= 1'b1;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               if (fire) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_data.opcode;
         rel_ff <= req_data.release_handle;
      end
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/hpa_checker.sv =====
// ----------------------------------------------------------------------------
// hpa_checker
// Port-level assertions for the handle pool allocator, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module hpa_port_props (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire hpa_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire hpa_pkg::rsp_type rsp_data
);

   import hpa_pkg::*;

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response beat dropped or changed while stalled");

   // failed or error responses carry handle zero
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STS_OK |-> rsp_data.granted_handle == '0)
      else $error("non-ok response with nonzero handle");

   // one request in flight: no accept right after an accept
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while previous still in flight");

   // no response straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind handle_pool_allocator hpa_port_props u_hpa_port_props (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ===== tb/sv/hpa_checker.sv =====
// ----------------------------------------------------------------------------
// hpa_checker
// Watches both channels of the handle pool allocator, predicts each response
// from its own model of the pool and compares it field by field.
// ----------------------------------------------------------------------------

module hpa_checker
   import hpa_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    req_ready,
   input  wire req_type req_data,
   input  wire logic    rsp_valid,
   input  wire logic    rsp_ready,
   input  wire rsp_type rsp_data,
   output int unsigned  mismatch_count,
   output int unsigned  grants_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   // pool model: FIFO of given-back handles, in-use map over the whole
   // handle space, count of handles minted so far
   logic [HANDLE_W-1:0]       recycled_q[$];
   bit [2**HANDLE_W-1:0]      handle_busy;
   logic [COUNT_W-1:0]        fresh_minted;

   rsp_type                   grant_expect_q[$];
   int unsigned               fails = 0;
   int unsigned               outstanding = 0;

   assign mismatch_count = fails;
   assign grants_pending = outstanding;

   task automatic report_mismatch(input string msg);
      $display("[%0t] hpa_checker: %s", $time, msg);
      fails++;
   endtask

   function automatic rsp_type predict_grant(input req_type beat);
      rsp_type r;
      r.granted_handle = '0;
      r.status         = STS_OK;
      case (beat.opcode)
         OP_ALLOC, OP_TRY: begin
            if (recycled_q.size() != 0) begin
               r.granted_handle = recycled_q.pop_front();
               handle_busy[r.granted_handle] = 1'b1;
            end else if (beat.opcode == OP_ALLOC && fresh_minted < HANDLES) begin
               r.granted_handle = fresh_minted[HANDLE_W-1:0];
               handle_busy[r.granted_handle] = 1'b1;
               fresh_minted = fresh_minted + 1'b1;
            end else begin
               r.status = STS_EMPTY;
            end
         end
         OP_FREE: begin
            if (!handle_busy[beat.release_handle]) begin
               r.status = STS_NOT_IN_USE;
            end else begin
               handle_busy[beat.release_handle] = 1'b0;
               recycled_q.push_back(beat.release_handle);
            end
         end
         default: ;  // unused opcode: no state change, zero response
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         recycled_q.delete();
         grant_expect_q.delete();
         handle_busy  = '0;
         fresh_minted = '0;
      end else begin
         // response first: it always belongs to an older request beat
         if (rsp_valid && rsp_ready) begin
            if (grant_expect_q.size() == 0) begin
               report_mismatch($sformatf("response beat with none outstanding: handle %0d status %0d",
                                         rsp_data.granted_handle, rsp_data.status));
            end else begin
               want = grant_expect_q.pop_front();
               if (rsp_data.granted_handle !== want.granted_handle)
                  report_mismatch($sformatf("granted_handle got %0d expected %0d",
                                            rsp_data.granted_handle, want.granted_handle));
               if (rsp_data.status !== want.status)
                  report_mismatch($sformatf("status got %0d expected %0d",
                                            rsp_data.status, want.status));
            end
         end
         if (req_valid && req_ready) begin
            grant_expect_q.push_back(predict_grant(req_data));
         end
      end
      outstanding = grant_expect_q.size();
   end

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the handle pool allocator: a directed opening,
// then random request streams under several idle and stall patterns, with
// hpa_checker doing all prediction and comparison.
// ----------------------------------------------------------------------------

module tb;
   import hpa_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0]  OP_UNUSED   = 2'd3;     // undefined opcode, must be a no-op
   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam int unsigned DRAIN_TAIL  = 16;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;

   int unsigned mismatch_count;
   int unsigned grants_pending;
   int unsigned cycle_count = 0;

   // idle knobs, percent of cycles
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct     = 0;

   // upper bound on handles minted so far; steers deallocates toward live handles
   int unsigned alloc_hint = 0;

   always #5 clock = ~clock;

   handle_pool_allocator i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   hpa_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .grants_pending (grants_pending)
   );

   // receiver: ready decided fresh every cycle at the falling edge
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic req_type make_beat(input logic [1:0] op, input logic [HANDLE_W-1:0] h);
      req_type b;
      b.opcode         = op;
      b.release_handle = h;
      return b;
   endfunction

   // Weighted op pick. Deallocates mostly aim at handles that may be live;
   // the rest hit anywhere in the handle space.
   function automatic req_type random_beat(input int unsigned alloc_w,
                                           input int unsigned try_w,
                                           input int unsigned free_w);
      int unsigned         pick;
      int unsigned         hi;
      logic [HANDLE_W-1:0] h;
      pick = $urandom_range(99);
      h    = HANDLE_W'($urandom());
      if (pick < alloc_w) begin
         alloc_hint++;
         return make_beat(OP_ALLOC, h);
      end
      if (pick < alloc_w + try_w) return make_beat(OP_TRY, h);
      if (pick < alloc_w + try_w + free_w) begin
         hi = (alloc_hint > 255) ? 255 : alloc_hint;
         if ($urandom_range(99) < 85) h = HANDLE_W'($urandom_range(hi, 0));
         return make_beat(OP_FREE, h);
      end
      return make_beat(OP_UNUSED, h);
   endfunction

   // Called and returns at a falling edge. Idle cycles show junk on the
   // payload so a block that ignores req_valid gets caught.
   task automatic send_beat(input req_type beat);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_data  <= req_type'($urandom());
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // sender holds off until every response has come back
   task automatic drain_grants();
      req_valid <= 1'b0;
      @(negedge clock);
      while (grants_pending != 0) @(negedge clock);
   endtask

   task automatic run_phase(input int unsigned beats,
                            input int unsigned idle, input int unsigned stall,
                            input int unsigned alloc_w, input int unsigned try_w,
                            input int unsigned free_w);
      send_idle_pct = idle;
      stall_pct     = stall;
      repeat (beats) send_beat(random_beat(alloc_w, try_w, free_w));
      drain_grants();
   endtask

   initial begin
      req_type opening[$];

      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed opening, no idling
      opening = '{
         make_beat(OP_TRY,    8'h00),   // try on a fresh pool: nothing freed
         make_beat(OP_FREE,   8'h00),   // release of a handle never issued
         make_beat(OP_FREE,   8'hFF),   // top of the handle space, not in use
         make_beat(OP_UNUSED, 8'hAA),   // undefined opcode is a no-op
         make_beat(OP_ALLOC,  8'h55),   // mints 0
         make_beat(OP_ALLOC,  8'h00),   // mints 1
         make_beat(OP_ALLOC,  8'hFF),   // mints 2
         make_beat(OP_TRY,    8'h00),   // still nothing freed
         make_beat(OP_FREE,   8'h01),
         make_beat(OP_FREE,   8'h01),   // double release
         make_beat(OP_FREE,   8'h00),
         make_beat(OP_TRY,    8'h00),   // oldest freed first: 1
         make_beat(OP_ALLOC,  8'h00),   // reuse 0 before minting
         make_beat(OP_ALLOC,  8'h00),   // queue empty again, mints 3
         make_beat(OP_UNUSED, 8'h55),
         make_beat(OP_FREE,   8'h02),
         make_beat(OP_FREE,   8'h03),
         make_beat(OP_FREE,   8'hFF),   // still not in use
         make_beat(OP_ALLOC,  8'h00),   // 2
         make_beat(OP_TRY,    8'h00),   // 3
         make_beat(OP_TRY,    8'h00)    // empty
      };
      alloc_hint = 4;
      foreach (opening[i]) send_beat(opening[i]);
      drain_grants();

      // fill phase runs the pool to exhaustion with back-to-back traffic,
      // then mixed traffic under each idle pattern
      run_phase(500, 0,  0,  75, 5,  17);
      run_phase(500, 76, 0,  40, 15, 42);
      run_phase(500, 0,  76, 40, 15, 42);
      run_phase(500, 24, 24, 35, 15, 47);

      stall_pct = 0;
      drain_grants();
      repeat (DRAIN_TAIL) @(negedge clock);

      if (mismatch_count == 0 && grants_pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/hpa_pkg.sv
hw/rtl/hpa_ram.sv
hw/rtl/handle_pool_allocator.sv
hw/rtl/hpa_checker.sv
tb/sv/hpa_checker.sv
tb/sv/tb.sv
